### rtl/rvde_pkg.sv
// Shared types, opcodes and status codes for the RV64 subset decode/execute block.
package rvde_pkg;

    localparam int XLEN      = 64;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;
    localparam int INST_W    = 32;

    // Item kinds on the input channel.
    localparam logic FUNC_EXEC = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    // Memory request codes.
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_WAIT_LOAD  = 3'd1;
    localparam logic [2:0] ST_EBREAK     = 3'd2;
    localparam logic [2:0] ST_ILLEGAL    = 3'd3;
    localparam logic [2:0] ST_UNEXPECTED = 3'd4;

    // Major opcodes.
    localparam logic [6:0] OPC_LOAD     = 7'h03;
    localparam logic [6:0] OPC_OPIMM    = 7'h13;
    localparam logic [6:0] OPC_AUIPC    = 7'h17;
    localparam logic [6:0] OPC_OPIMM32  = 7'h1B;
    localparam logic [6:0] OPC_STORE    = 7'h23;
    localparam logic [6:0] OPC_OP       = 7'h33;
    localparam logic [6:0] OPC_OP32     = 7'h3B;
    localparam logic [6:0] OPC_BRANCH   = 7'h63;
    localparam logic [6:0] OPC_JALR     = 7'h67;
    localparam logic [6:0] OPC_JAL      = 7'h6F;

    // Minor function codes.
    localparam logic [2:0] F3_ADD   = 3'd0;
    localparam logic [2:0] F3_SLL   = 3'd1;
    localparam logic [2:0] F3_WORD  = 3'd2;
    localparam logic [2:0] F3_DWORD = 3'd3;
    localparam logic [2:0] F3_SLTIU = 3'd3;
    localparam logic [2:0] F3_SRL   = 3'd5;
    localparam logic [2:0] F3_BEQ   = 3'd0;
    localparam logic [2:0] F3_BNE   = 3'd1;
    localparam logic [2:0] F3_BGE   = 3'd5;
    localparam logic [6:0] F7_ZERO  = 7'h00;
    localparam logic [6:0] F7_SUB   = 7'h20;

    localparam logic [INST_W-1:0] INST_EBREAK = 32'h0010_0073;
    localparam logic [REG_AW-1:0] REG_A0      = 5'd10;

    // One input beat.
    typedef struct packed {
        logic              func;
        logic [INST_W-1:0] inst;
        logic [XLEN-1:0]   pc;
        logic [XLEN-1:0]   load_data;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic [XLEN-1:0] next_pc;
        logic [1:0]      mem_op;
        logic [XLEN-1:0] mem_addr;
        logic            mem_doubleword;
        logic [XLEN-1:0] store_data;
        logic [2:0]      status;
        logic [XLEN-1:0] exit_value;
    } t_result;

    // Register file write-back.
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_wb;

    // Outstanding load bookkeeping.
    typedef struct packed {
        logic              pending;
        logic [REG_AW-1:0] dest;
        logic              is_word;
    } t_ld_state;

endpackage

### rtl/rvde_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rvde_ram
    #(
        parameter int WIDTH = 64,
        parameter int DEPTH = 32
    )
    (
        input  logic                     i_clk,
        input  logic                     i_we,
        input  logic [$clog2(DEPTH)-1:0] i_waddr,
        input  logic [WIDTH-1:0]         i_wdata,
        input  logic                     i_re,
        input  logic [$clog2(DEPTH)-1:0] i_raddr,
        output logic [WIDTH-1:0]         o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port; a read of the same address in the same cycle returns old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rvde_exec.sv
// Instruction decode, ALU, branch resolution and load bookkeeping for one item.
module rvde_exec
    import rvde_pkg::*;
    (
        input  t_item           i_item,
        input  logic [XLEN-1:0] i_rs1,
        input  logic [XLEN-1:0] i_rs2,
        input  logic [XLEN-1:0] i_a0,
        input  t_ld_state       i_ld,
        output t_result         o_res,
        output t_wb             o_wb,
        output t_ld_state       o_ld
    );

    logic [INST_W-1:0] w;
    logic [6:0]        opc;
    logic [2:0]        f3;
    logic [6:0]        f7;
    logic [REG_AW-1:0] rd;
    logic [5:0]        sh;
    logic [XLEN-1:0]   imm_i;
    logic [XLEN-1:0]   imm_s;
    logic [XLEN-1:0]   imm_b;
    logic [XLEN-1:0]   imm_j;
    logic [XLEN-1:0]   imm_u;
    logic [XLEN-1:0]   ag_sum;
    logic [XLEN-1:0]   pc_sum;
    logic [XLEN-1:0]   pc_inc;
    logic [XLEN-1:0]   add_rr;
    logic [XLEN-1:0]   sub_rr;
    logic              is_store;
    logic              lt_imm;
    logic              ge_signed;
    logic              take;
    logic [XLEN-1:0]   ld_val;

    // Field split and immediate formats.
    assign w     = i_item.inst;
    assign opc   = w[6:0];
    assign f3    = w[14:12];
    assign f7    = w[31:25];
    assign rd    = w[11:7];
    assign sh    = w[25:20];
    assign imm_i = {{52{w[31]}}, w[31:20]};
    assign imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
    assign imm_b = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_j = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign imm_u = {{32{w[31]}}, w[31:12], 12'b0};

    // Shared adders: register base plus immediate, pc plus immediate.
    assign is_store  = (opc == OPC_STORE);
    assign ag_sum    = i_rs1 + (is_store ? imm_s : imm_i);
    assign pc_sum    = i_item.pc + ((opc == OPC_AUIPC) ? imm_u :
                                    (opc == OPC_JAL)   ? imm_j : imm_b);
    assign pc_inc    = i_item.pc + 64'd4;
    assign add_rr    = i_rs1 + i_rs2;
    assign sub_rr    = i_rs1 - i_rs2;
    assign lt_imm    = (i_rs1 < imm_i);
    assign ge_signed = ($signed(i_rs1) >= $signed(i_rs2));

    // Branch condition.
    always_comb begin
        case (f3)
            F3_BEQ:  take = (i_rs1 == i_rs2);
            F3_BNE:  take = (i_rs1 != i_rs2);
            F3_BGE:  take = ge_signed;
            default: take = 1'b0;
        endcase
    end

    // Returned load data, sign-extended for a word load.
    assign ld_val = i_ld.is_word ? {{32{i_item.load_data[31]}}, i_item.load_data[31:0]}
                                 : i_item.load_data;

    // Main decode and execute.
    always_comb begin
        o_res.next_pc        = pc_inc;
        o_res.mem_op         = MEM_NONE;
        o_res.mem_addr       = '0;
        o_res.mem_doubleword = 1'b0;
        o_res.store_data     = '0;
        o_res.status         = ST_DONE;
        o_res.exit_value     = '0;
        o_wb.en              = 1'b0;
        o_wb.addr            = rd;
        o_wb.data            = '0;
        o_ld                 = i_ld;

        if (i_item.func == FUNC_DATA) begin
            o_res.next_pc = '0;
            if (i_ld.pending) begin
                o_wb.en      = 1'b1;
                o_wb.addr    = i_ld.dest;
                o_wb.data    = ld_val;
                o_ld.pending = 1'b0;
            end else begin
                o_res.status = ST_UNEXPECTED;
            end
        end else if (i_ld.pending) begin
            // Retry the same instruction once the load data has arrived.
            o_res.next_pc = i_item.pc;
            o_res.status  = ST_WAIT_LOAD;
        end else if (opc == OPC_AUIPC) begin
            o_wb.en   = 1'b1;
            o_wb.data = pc_sum;
        end else if (opc == OPC_LOAD && (f3 == F3_DWORD || f3 == F3_WORD)) begin
            o_res.mem_op         = MEM_READ;
            o_res.mem_addr       = ag_sum;
            o_res.mem_doubleword = (f3 == F3_DWORD);
            o_res.status         = ST_WAIT_LOAD;
            o_ld.pending         = 1'b1;
            o_ld.dest            = rd;
            o_ld.is_word         = (f3 == F3_WORD);
        end else if (opc == OPC_STORE && f3 == F3_DWORD) begin
            o_res.mem_op         = MEM_WRITE;
            o_res.mem_addr       = ag_sum;
            o_res.mem_doubleword = 1'b1;
            o_res.store_data     = i_rs2;
        end else if (opc == OPC_OPIMM && f3 == F3_ADD) begin
            o_wb.en   = 1'b1;
            o_wb.data = ag_sum;
        end else if (opc == OPC_OPIMM && f3 == F3_SLTIU) begin
            o_wb.en   = 1'b1;
            o_wb.data = {63'd0, lt_imm};
        end else if (opc == OPC_OPIMM && f3 == F3_SLL && w[31:26] == 6'd0) begin
            o_wb.en   = 1'b1;
            o_wb.data = i_rs1 << sh;
        end else if (opc == OPC_OPIMM && f3 == F3_SRL && w[31:26] == 6'd0) begin
            o_wb.en   = 1'b1;
            o_wb.data = i_rs1 >> sh;
        end else if (opc == OPC_OPIMM32 && f3 == F3_ADD) begin
            o_wb.en   = 1'b1;
            o_wb.data = {{32{ag_sum[31]}}, ag_sum[31:0]};
        end else if (opc == OPC_OP32 && f3 == F3_ADD && f7 == F7_ZERO) begin
            o_wb.en   = 1'b1;
            o_wb.data = {{32{add_rr[31]}}, add_rr[31:0]};
        end else if (opc == OPC_OP && f3 == F3_ADD && f7 == F7_ZERO) begin
            o_wb.en   = 1'b1;
            o_wb.data = add_rr;
        end else if (opc == OPC_OP && f3 == F3_ADD && f7 == F7_SUB) begin
            o_wb.en   = 1'b1;
            o_wb.data = sub_rr;
        end else if (opc == OPC_JAL) begin
            o_res.next_pc = pc_sum;
            o_wb.en       = 1'b1;
            o_wb.data     = pc_inc;
        end else if (opc == OPC_JALR && f3 == F3_ADD) begin
            o_res.next_pc = {ag_sum[XLEN-1:1], 1'b0};
            o_wb.en       = 1'b1;
            o_wb.data     = pc_inc;
        end else if (opc == OPC_BRANCH && (f3 == F3_BEQ || f3 == F3_BNE || f3 == F3_BGE)) begin
            if (take) begin
                o_res.next_pc = pc_sum;
            end
        end else if (w == INST_EBREAK) begin
            o_res.status     = ST_EBREAK;
            o_res.exit_value = i_a0;
        end else begin
            o_res.status = ST_ILLEGAL;
        end

        // Register x0 is never written.
        if (o_wb.addr == '0) begin
            o_wb.en = 1'b0;
        end
    end

endmodule

### rtl/rv64_subset_decode_execute.sv
// Top level of the RV64 subset decode/execute block: pipeline, register file, result register.
//
// Input channel: i_valid, o_stall and the fields i_func, i_inst, i_pc, i_load_data.
// A beat is taken at a rising edge with i_valid high and o_stall low. With i_func low
// the beat executes i_inst at i_pc; with i_func high it returns data for a pending load.
// Output channel: o_valid, i_stall and the result fields; a beat leaves at an edge with
// o_valid high and i_stall low. Every input beat yields exactly one result beat.
// The edge that takes a beat reads the register file into the execute register, and the
// result register loads from it once empty or draining. Throughput is one beat per cycle
// while the receiver does not stall; the register file read ports and a one-entry write
// bypass let dependent instructions follow each other with no bubble. A load issues a
// read request and the following data beat completes it; instructions arriving in between
// report a wait. When the receiver stalls, the result register holds, the execute stage
// fills behind it and then o_stall rises until the result beat is taken. Reset clears the
// register file (through per-entry valid bits, so it takes effect at once), the pending-load
// state and both pipeline valids; no beat is lost or repeated across a stall.
module rv64_subset_decode_execute
    import rvde_pkg::*;
    (
        input  logic            i_clk,
        input  logic            i_rst_n,
        input  logic            i_valid,
        output logic            o_stall,
        input  logic            i_func,
        input  logic [31:0]     i_inst,
        input  logic [63:0]     i_pc,
        input  logic [63:0]     i_load_data,
        output logic            o_valid,
        input  logic            i_stall,
        output logic [63:0]     o_next_pc,
        output logic [1:0]      o_mem_op,
        output logic [63:0]     o_mem_addr,
        output logic            o_mem_doubleword,
        output logic [63:0]     o_store_data,
        output logic [2:0]      o_status,
        output logic [63:0]     o_exit_value
    );

    logic                 r_s1_valid;
    t_item                r_s1_item;
    logic                 r_out_valid;
    t_result              r_out;
    t_ld_state            r_ld;
    logic [REG_COUNT-1:0] r_rf_vld;
    logic [XLEN-1:0]      r_a0;
    logic                 r_vld1;
    logic                 r_vld2;
    logic                 r_hit1;
    logic                 r_hit2;
    logic [XLEN-1:0]      r_byp_data;

    logic                 in_acc;
    logic                 out_load;
    logic                 s1_adv;
    logic                 wr_en;
    logic [REG_AW-1:0]    raddr1;
    logic [REG_AW-1:0]    raddr2;
    logic [XLEN-1:0]      q1;
    logic [XLEN-1:0]      q2;
    logic [XLEN-1:0]      rs1_val;
    logic [XLEN-1:0]      rs2_val;
    t_result              ex_res;
    t_wb                  ex_wb;
    t_ld_state            ex_ld;

    // Handshake: the result register loads when empty or draining.
    assign out_load = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_load;
    assign o_stall  = r_s1_valid && !out_load;
    assign in_acc   = i_valid && !o_stall;
    assign wr_en    = s1_adv && ex_wb.en;

    assign raddr1 = i_inst[19:15];
    assign raddr2 = i_inst[24:20];

    // Two copies of the register file, one per source operand.
    rvde_ram #(
        .WIDTH (64),
        .DEPTH (32)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ex_wb.addr),
        .i_wdata (ex_wb.data),
        .i_re    (in_acc),
        .i_raddr (raddr1),
        .o_rdata (q1)
    );

    rvde_ram #(
        .WIDTH (64),
        .DEPTH (32)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ex_wb.addr),
        .i_wdata (ex_wb.data),
        .i_re    (in_acc),
        .i_raddr (raddr2),
        .o_rdata (q2)
    );

    // Operand select: bypass from the write in the same edge, else RAM or reset zero.
    assign rs1_val = r_hit1 ? r_byp_data : (r_vld1 ? q1 : '0);
    assign rs2_val = r_hit2 ? r_byp_data : (r_vld2 ? q2 : '0);

    rvde_exec u_exec (
        .i_item (r_s1_item),
        .i_rs1  (rs1_val),
        .i_rs2  (rs2_val),
        .i_a0   (r_a0),
        .i_ld   (r_ld),
        .o_res  (ex_res),
        .o_wb   (ex_wb),
        .o_ld   (ex_ld)
    );

    // Execute-stage input register and operand bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (in_acc) begin
            r_s1_item.func      <= i_func;
            r_s1_item.inst      <= i_inst;
            r_s1_item.pc        <= i_pc;
            r_s1_item.load_data <= i_load_data;
            r_vld1              <= r_rf_vld[raddr1];
            r_vld2              <= r_rf_vld[raddr2];
            r_hit1              <= wr_en && (ex_wb.addr == raddr1);
            r_hit2              <= wr_en && (ex_wb.addr == raddr2);
            r_byp_data          <= ex_wb.data;
        end
    end

    // Architectural state: entry valid bits, a0 copy, pending load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
            r_a0     <= '0;
            r_ld     <= '0;
        end else if (s1_adv) begin
            r_ld <= ex_ld;
            if (ex_wb.en) begin
                r_rf_vld[ex_wb.addr] <= 1'b1;
                if (ex_wb.addr == REG_A0) begin
                    r_a0 <= ex_wb.data;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
        if (s1_adv) begin
            r_out <= ex_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_next_pc        = r_out.next_pc;
    assign o_mem_op         = r_out.mem_op;
    assign o_mem_addr       = r_out.mem_addr;
    assign o_mem_doubleword = r_out.mem_doubleword;
    assign o_store_data     = r_out.store_data;
    assign o_status         = r_out.status;
    assign o_exit_value     = r_out.exit_value;

endmodule
